### design/sccnt_pkg.sv
// ----------------------------------------------------------------------------
// sccnt_pkg
// shared constants and types of the sorted code count table
// ----------------------------------------------------------------------------
`default_nettype none

package sccnt_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int ENTRY_BITS  = IDX_BITS + 1;
    localparam int CODE_BITS   = 64;
    localparam int COUNT_BITS  = 32;
    localparam int SUM_BITS    = 64;

    typedef logic [1:0]            action_t;
    typedef logic [2:0]            status_t;
    typedef logic [CODE_BITS-1:0]  code_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SUM_BITS-1:0]   sum_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [ENTRY_BITS-1:0] entry_t;

    localparam action_t ACT_LOAD  = 2'd0;
    localparam action_t ACT_START = 2'd1;
    localparam action_t ACT_QUERY = 2'd2;
    localparam action_t ACT_SCAN  = 2'd3;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_ORDER = 3'd1;
    localparam status_t ST_FULL  = 3'd2;
    localparam status_t ST_SAT   = 3'd3;
    localparam status_t ST_DONE  = 3'd4;

    localparam count_t COUNT_MAX = '1;
    localparam sum_t   SUM_MAX   = '1;
    localparam entry_t DEPTH_E   = entry_t'(TABLE_DEPTH);

endpackage

`default_nettype wire

### design/sccnt_if.sv
// ----------------------------------------------------------------------------
// sccnt_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sccnt_req_if;
    import sccnt_pkg::*;
    logic    valid;
    logic    ready;
    action_t action;
    code_t   code;
    idx_t    start_index;
    code_t   start_code;
    modport source (output valid, action, code, start_index, start_code, input ready);
    modport sink   (input valid, action, code, start_index, start_code, output ready);
endinterface

interface sccnt_rsp_if;
    import sccnt_pkg::*;
    logic    valid;
    logic    ready;
    entry_t  entry_index;
    sum_t    value;
    count_t  max_count;
    logic    matched;
    logic    last;
    status_t status;
    modport source (output valid, entry_index, value, max_count, matched, last, status,
                    input ready);
    modport sink   (input valid, entry_index, value, max_count, matched, last, status,
                    output ready);
endinterface

`default_nettype wire

### design/sorted_code_count_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_code_count_table_unit
// delta coded table of sorted codes with occurrence counts, merge and scan
// ----------------------------------------------------------------------------
//  channel   | dir | fields
//  request   | in  | action, code, start_index, start_code
//  result    | out | entry_index, value, max_count, matched, last, status
//
//  a request is captured, then executed from registers
//  count and delta reads come from the registered table memory outputs
//  a query steps through S_QADV and back to S_EXEC per entry the cursor walks over
//  reset clears state, total, cursor, scan and valid registers; request, result fields and table memories stay unknown
//  a full result register stalls the last step until result.ready
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_code_count_table_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sccnt_req_if.sink  request,
    sccnt_rsp_if.source result
);
    import sccnt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_LDINC = 6'b000100,
        S_QADV  = 6'b001000,
        S_QBUMP = 6'b010000,
        S_SACC  = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    action_t act_reg;
    code_t   code_reg, scode_reg;
    idx_t    sidx_reg;

    entry_t  total_reg, total_next;
    code_t   last_code_reg, last_code_next;
    idx_t    cur_idx_reg, cur_idx_next;
    code_t   cur_code_reg, cur_code_next;
    logic    cur_done_reg, cur_done_next;
    sum_t    found_reg, found_next;
    entry_t  pos_reg, pos_next;
    sum_t    sum_reg, sum_next;
    count_t  largest_reg, largest_next;

    logic    out_valid_reg;
    entry_t  o_idx_reg, o_idx_next;
    sum_t    o_val_reg, o_val_next;
    count_t  o_max_reg, o_max_next;
    logic    o_match_reg, o_match_next;
    logic    o_last_reg, o_last_next;
    status_t o_st_reg, o_st_next;
    logic    emit;

    code_t   delta_mem [TABLE_DEPTH];
    count_t  count_mem [TABLE_DEPTH];
    code_t   delta_rd;
    count_t  count_rd;
    idx_t    rd_addr, wr_addr;
    logic    delta_re, count_re, delta_we, count_we;
    code_t   delta_wd;
    count_t  count_wd;

    logic    slot_free;
    logic    accept;
    entry_t  cur_next_e;
    logic    cnt_sat;
    idx_t    last_idx;

    assign slot_free      = !out_valid_reg || result.ready;
    assign request.ready  = (state_reg == S_IDLE);
    assign accept         = request.valid && request.ready;
    assign cur_next_e     = {1'b0, cur_idx_reg} + entry_t'(1);
    assign cnt_sat        = (count_rd == COUNT_MAX);
    assign last_idx       = idx_t'(total_reg - entry_t'(1));

    always_ff @(posedge clk)
    begin
        if (delta_we)
        begin
            delta_mem[wr_addr] <= delta_wd;
        end
        if (delta_re)
        begin
            delta_rd <= delta_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_we)
        begin
            count_mem[wr_addr] <= count_wd;
        end
        if (count_re)
        begin
            count_rd <= count_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        last_code_next = last_code_reg;
        cur_idx_next   = cur_idx_reg;
        cur_code_next  = cur_code_reg;
        cur_done_next  = cur_done_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        largest_next   = largest_reg;
        emit           = 1'b0;
        o_idx_next     = o_idx_reg;
        o_val_next     = o_val_reg;
        o_max_next     = largest_reg;
        o_match_next   = 1'b0;
        o_last_next    = 1'b0;
        o_st_next      = ST_OK;
        rd_addr        = cur_idx_reg;
        wr_addr        = cur_idx_reg;
        delta_re       = 1'b0;
        count_re       = 1'b0;
        delta_we       = 1'b0;
        count_we       = 1'b0;
        delta_wd       = '0;
        count_wd       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (act_reg)
                    ACT_LOAD:
                    begin
                        if (total_reg != '0 && code_reg == last_code_reg)
                        begin
                            rd_addr    = last_idx;
                            count_re   = 1'b1;
                            state_next = S_LDINC;
                        end
                        else if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            o_idx_next = total_reg;
                            o_val_next = '0;
                            if (total_reg != '0 && code_reg < last_code_reg)
                            begin
                                o_st_next = ST_ORDER;
                            end
                            else if (total_reg == DEPTH_E)
                            begin
                                o_st_next = ST_FULL;
                            end
                            else
                            begin
                                wr_addr        = idx_t'(total_reg);
                                delta_we       = 1'b1;
                                count_we       = 1'b1;
                                delta_wd       = (total_reg == '0) ? '0
                                                 : code_reg - last_code_reg;
                                count_wd       = count_t'(1);
                                total_next     = total_reg + entry_t'(1);
                                last_code_next = code_reg;
                                o_val_next     = sum_t'(1);
                            end
                        end
                    end
                    ACT_START:
                    begin
                        if (slot_free)
                        begin
                            emit          = 1'b1;
                            state_next    = S_IDLE;
                            cur_idx_next  = sidx_reg;
                            cur_code_next = scode_reg;
                            found_next    = '0;
                            cur_done_next = ({1'b0, sidx_reg} >= total_reg);
                            o_idx_next    = {1'b0, sidx_reg};
                            o_val_next    = '0;
                            o_st_next     = cur_done_next ? ST_DONE : ST_OK;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (!cur_done_reg && code_reg > cur_code_reg
                            && cur_next_e < total_reg)
                        begin
                            rd_addr    = idx_t'(cur_next_e);
                            delta_re   = 1'b1;
                            state_next = S_QADV;
                        end
                        else if (!cur_done_reg && code_reg == cur_code_reg)
                        begin
                            count_re   = 1'b1;
                            state_next = S_QBUMP;
                        end
                        else if (slot_free)
                        begin
                            emit          = 1'b1;
                            state_next    = S_IDLE;
                            cur_done_next = cur_done_reg || (code_reg > cur_code_reg);
                            o_idx_next    = {1'b0, cur_idx_reg};
                            o_val_next    = found_reg;
                            o_st_next     = cur_done_next ? ST_DONE : ST_OK;
                        end
                    end
                    default:
                    begin
                        if (pos_reg < total_reg)
                        begin
                            rd_addr    = idx_t'(pos_reg);
                            count_re   = 1'b1;
                            state_next = S_SACC;
                        end
                        else if (slot_free)
                        begin
                            emit         = 1'b1;
                            state_next   = S_IDLE;
                            o_idx_next   = total_reg;
                            o_val_next   = sum_reg;
                            o_last_next  = 1'b1;
                            pos_next     = '0;
                            sum_next     = '0;
                            largest_next = '0;
                        end
                    end
                endcase
            end
            S_LDINC:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    wr_addr    = last_idx;
                    count_we   = 1'b1;
                    count_wd   = cnt_sat ? count_rd : count_rd + count_t'(1);
                    o_idx_next = {1'b0, last_idx};
                    o_val_next = sum_t'(count_wd);
                    o_st_next  = cnt_sat ? ST_SAT : ST_OK;
                end
            end
            S_QADV:
            begin
                cur_idx_next  = idx_t'(cur_next_e);
                cur_code_next = cur_code_reg + delta_rd;
                state_next    = S_EXEC;
            end
            S_QBUMP:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    state_next   = S_IDLE;
                    count_we     = 1'b1;
                    count_wd     = cnt_sat ? count_rd : count_rd + count_t'(1);
                    found_next   = (found_reg == SUM_MAX) ? found_reg
                                   : found_reg + sum_t'(1);
                    o_idx_next   = {1'b0, cur_idx_reg};
                    o_val_next   = found_next;
                    o_match_next = 1'b1;
                    o_st_next    = cnt_sat ? ST_SAT : ST_OK;
                end
            end
            S_SACC:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    state_next   = S_IDLE;
                    sum_next     = sum_reg + sum_t'(count_rd);
                    largest_next = (count_rd > largest_reg) ? count_rd : largest_reg;
                    o_idx_next   = pos_reg;
                    o_val_next   = sum_next;
                    o_max_next   = largest_next;
                    pos_next     = pos_reg + entry_t'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            last_code_reg <= '0;
            cur_idx_reg   <= '0;
            cur_code_reg  <= '0;
            cur_done_reg  <= 1'b0;
            found_reg     <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            last_code_reg <= last_code_next;
            cur_idx_reg   <= cur_idx_next;
            cur_code_reg  <= cur_code_next;
            cur_done_reg  <= cur_done_next;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            largest_reg   <= largest_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= request.action;
            code_reg  <= request.code;
            sidx_reg  <= request.start_index;
            scode_reg <= request.start_code;
        end
        if (emit)
        begin
            o_idx_reg   <= o_idx_next;
            o_val_reg   <= o_val_next;
            o_max_reg   <= o_max_next;
            o_match_reg <= o_match_next;
            o_last_reg  <= o_last_next;
            o_st_reg    <= o_st_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.entry_index = o_idx_reg;
    assign result.value       = o_val_reg;
    assign result.max_count   = o_max_reg;
    assign result.matched     = o_match_reg;
    assign result.last        = o_last_reg;
    assign result.status      = o_st_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= DEPTH_E)
        else $error("entry total beyond table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= total_reg)
        else $error("scan position past entry total");

    a_adv_return: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QADV |=> state_reg == S_EXEC)
        else $error("cursor step did not return to compare");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

endmodule

`default_nettype wire
